### rtl/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared constants, register codes and pipeline sideband types of the
// Crystal Ball density evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpe_pkg;

  localparam int unsigned N_SQR    = 28;
  localparam int unsigned N_HORNER = 12;
  // input transaction to result strobe, in clock cycles
  localparam int unsigned LATENCY  = 75;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [31:0] DENS_MAX  = 32'hFFFF_FFFF;

  localparam int unsigned IPART_W  = 24;
  localparam int unsigned CORE_V_W = 40;

  localparam logic [31:0] RST_MEAN          = 32'd65536;
  localparam logic [31:0] RST_INV_SIGMA     = 32'd65536;
  localparam logic [31:0] RST_ALPHA         = 32'd65536;
  localparam logic [22:0] RST_TAIL_EXPONENT = 23'd131072;
  localparam logic [31:0] RST_GAUSS_SCALE   = 32'd40685;
  localparam logic [31:0] RST_TAIL_SCALE    = 32'd98711;
  localparam logic [31:0] RST_TAIL_OFFSET   = 32'd65536;

  typedef enum logic [2:0] {
    CFG_MEAN          = 3'd0,
    CFG_INV_SIGMA     = 3'd1,
    CFG_ALPHA         = 3'd2,
    CFG_TAIL_EXPONENT = 3'd3,
    CFG_GAUSS_SCALE   = 3'd4,
    CFG_TAIL_SCALE    = 3'd5,
    CFG_TAIL_OFFSET   = 3'd6
  } cfg_idx_e;

  // sideband through the log2 section
  typedef struct packed {
    logic                    valid;
    logic                    in_tail;
    logic                    force_max;
    logic                    force_zero;
    logic signed [7:0]       l2e;
    logic [CORE_V_W-1:0]     core_v;
  } front_t;

  // sideband through the exponential section
  typedef struct packed {
    logic                    valid;
    logic                    in_tail;
    logic                    force_max;
    logic                    force_zero;
    logic                    up;
    logic [IPART_W-1:0]      ipart;
  } back_t;

endpackage

`default_nettype wire

### rtl/cbpe_sqr_cell.sv
// ----------------------------------------------------------------------------
// cbpe_sqr_cell
// One step of the log2 fraction: square the Q31 mantissa, renormalise and
// shift the resulting fraction bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_sqr_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbpe_pkg::front_t side_i,
  input  logic [31:0]      m_i,
  input  logic [27:0]      frac_i,
  output cbpe_pkg::front_t side_o,
  output logic [31:0]      m_o,
  output logic [27:0]      frac_o
);
  import cbpe_pkg::*;

  logic [63:0] sq;
  logic [32:0] sh;
  logic [31:0] m_d;
  logic [27:0] frac_d;
  front_t      side_q;
  logic [31:0] m_q;
  logic [27:0] frac_q;

  always_comb begin
    sq = 64'(m_i) * 64'(m_i);
    sh = sq[63:31];
    // mantissa reached two: halve and record a one
    if (sh[32]) begin
      m_d = sh[32:1];
    end else begin
      m_d = sh[31:0];
    end
    frac_d = {frac_i[26:0], sh[32]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    frac_q <= frac_d;
  end

  assign side_o = side_q;
  assign m_o    = m_q;
  assign frac_o = frac_q;

endmodule

`default_nettype wire

### rtl/cbpe_horner_cell.sv
// ----------------------------------------------------------------------------
// cbpe_horner_cell
// One Horner step of exp(-r): s <= 1 - ((r * s) >> 32) / K, in three stages
// (product, reciprocal estimate, correction).
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_horner_cell #(
  parameter int unsigned K = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbpe_pkg::back_t side_i,
  input  logic [31:0]     r_i,
  input  logic [32:0]     s_i,
  output cbpe_pkg::back_t side_o,
  output logic [31:0]     r_o,
  output logic [32:0]     s_o
);
  import cbpe_pkg::*;

  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
  localparam logic [35:0] KW    = 36'(K);

  logic [64:0] prod_a;
  logic [64:0] prod_b;
  logic [35:0] rem;
  logic [31:0] quo;

  back_t       a_side_q, b_side_q, c_side_q;
  logic [31:0] a_r_q, b_r_q, c_r_q;
  logic [31:0] a_p_q, b_p_q;
  logic [31:0] b_q0_q;
  logic [32:0] c_s_q;

  always_comb begin
    prod_a = 65'(r_i) * 65'(s_i);
    prod_b = 65'(a_p_q) * 65'(RECIP);
    // estimate is low by at most one
    rem    = 36'(b_p_q) - 36'(b_q0_q) * KW;
    quo    = (rem >= KW) ? (b_q0_q + 32'd1) : b_q0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q <= '0;
      b_side_q <= '0;
      c_side_q <= '0;
    end else begin
      a_side_q <= side_i;
      b_side_q <= a_side_q;
      c_side_q <= b_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_r_q  <= r_i;
    a_p_q  <= prod_a[63:32];
    b_r_q  <= a_r_q;
    b_p_q  <= a_p_q;
    b_q0_q <= prod_b[63:32];
    c_r_q  <= b_r_q;
    c_s_q  <= ONE_Q32 - 33'(quo);
  end

  assign side_o = c_side_q;
  assign r_o    = c_r_q;
  assign s_o    = c_s_q;

endmodule

`default_nettype wire

### rtl/crystal_ball_pdf_eval_unit.sv
// ----------------------------------------------------------------------------
// crystal_ball_pdf_eval_unit
// Low-side Crystal Ball density of a signed fixed-point sample, fully
// pipelined, one result per sample.
// ----------------------------------------------------------------------------
// A sample is taken in every cycle (busy stays low) and its density appears
// on density_o / in_tail_o with done_o at the end of the pipeline, in order,
// one result per sample. The result is shown for one cycle only and cannot
// be held off. The latency is set by the 28 squaring cells of the log2
// chain and the 12 three-stage Horner cells of the exponential, plus the
// input, scaling, region, normalisation, exponent and output stages. Write
// configuration only while no sample is in flight.
`default_nettype none

module crystal_ball_pdf_eval_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] sample_x_i,
  output logic        done_o,
  output logic [31:0] density_o,
  output logic        in_tail_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import cbpe_pkg::*;

  localparam int unsigned TW  = 65 - FRAC_BITS;
  localparam int unsigned BMW = TW + 1;
  localparam int unsigned NCH = (BMW + 7) / 8;
  localparam int unsigned BPW = NCH * 8;
  localparam int unsigned PW  = $clog2(BPW);
  localparam int unsigned VW  = 64 - FRAC_BITS;
  localparam int unsigned UW  = FRAC_BITS + 7;
  localparam int unsigned SQW = 2 * FRAC_BITS + 8;
  localparam int unsigned CPW = FRAC_BITS + 38;
  localparam logic [TW-1:0] CORE_LIM = TW'(12) << FRAC_BITS;

  // configuration
  logic [31:0] mean_q, inv_sigma_q, alpha_q, gauss_scale_q, tail_scale_q;
  logic [31:0] tail_offset_q;
  logic [22:0] tail_exp_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q        <= RST_MEAN;
      inv_sigma_q   <= RST_INV_SIGMA;
      alpha_q       <= RST_ALPHA;
      tail_exp_q    <= RST_TAIL_EXPONENT;
      gauss_scale_q <= RST_GAUSS_SCALE;
      tail_scale_q  <= RST_TAIL_SCALE;
      tail_offset_q <= RST_TAIL_OFFSET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MEAN:          mean_q        <= cfg_data_i;
        CFG_INV_SIGMA:     inv_sigma_q   <= cfg_data_i;
        CFG_ALPHA:         alpha_q       <= cfg_data_i;
        CFG_TAIL_EXPONENT: tail_exp_q    <= cfg_data_i[22:0];
        CFG_GAUSS_SCALE:   gauss_scale_q <= cfg_data_i;
        CFG_TAIL_SCALE:    tail_scale_q  <= cfg_data_i;
        CFG_TAIL_OFFSET:   tail_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: distance from the mean
  logic [32:0] diff_d, dmag_d;
  logic        s1_valid_q, s1_dneg_q;
  logic [32:0] s1_dmag_q;

  always_comb begin
    diff_d = {sample_x_i[31], sample_x_i} - {mean_q[31], mean_q};
    dmag_d = diff_d[32] ? (~diff_d + 33'd1) : diff_d;
  end

  // stage 2: scale by the reciprocal width
  logic [64:0]   prod2;
  logic          s2_valid_q, s2_dneg_q;
  logic [TW-1:0] s2_tmag_q;

  assign prod2 = 65'(s1_dmag_q) * 65'(inv_sigma_q);

  // stage 3: region, core square and tail base
  logic            tail3, zero3, fmax3;
  logic [SQW-1:0]  sq3;
  logic [TW+1:0]   b3;
  logic            s3_valid_q, s3_tail_q, s3_zero_q, s3_fmax_q;
  logic [UW-1:0]   s3_u_q;
  logic [BMW-1:0]  s3_bmag_q;

  always_comb begin
    if (s2_dneg_q) begin
      tail3 = (s2_tmag_q >= TW'(alpha_q));
    end else begin
      tail3 = (s2_tmag_q == '0) && (alpha_q == '0);
    end
    zero3 = (s2_tmag_q >= CORE_LIM);
    sq3   = SQW'(s2_tmag_q[FRAC_BITS+3:0]) * SQW'(s2_tmag_q[FRAC_BITS+3:0]);
    // in the tail t is minus tmag, so the base is offset plus tmag
    b3    = {{(TW-30){tail_offset_q[31]}}, tail_offset_q} + {2'b00, s2_tmag_q};
    fmax3 = b3[TW+1] || (b3 == '0);
  end

  // stage 4: core exponent and per-byte leading-one search
  logic [CPW-1:0]  cprod;
  logic [BPW-1:0]  bpad4;
  logic [NCH-1:0]  nz4;
  logic [2:0]      lidx4 [NCH];
  front_t          side4;
  front_t          s4_side_q;
  logic [BPW-1:0]  s4_bpad_q;
  logic [NCH-1:0]  s4_nz_q;
  logic [2:0]      s4_lidx_q [NCH];

  always_comb begin
    cprod = CPW'(s3_u_q) * CPW'(LOG2E_Q30);
    bpad4 = BPW'(s3_bmag_q);
    for (int c = 0; c < NCH; c++) begin
      nz4[c]   = |bpad4[c*8 +: 8];
      lidx4[c] = '0;
      for (int j = 0; j < 8; j++) begin
        if (bpad4[c*8+j]) begin
          lidx4[c] = 3'(j);
        end
      end
    end
    side4.valid      = s3_valid_q;
    side4.in_tail    = s3_tail_q;
    side4.force_max  = s3_tail_q && s3_fmax_q;
    side4.force_zero = !s3_tail_q && s3_zero_q;
    side4.l2e        = '0;
    side4.core_v     = cprod[CPW-1:FRAC_BITS-2];
  end

  // stage 5: leading-one position
  logic [PW-1:0]  p5;
  front_t         s5_side_q;
  logic [BPW-1:0] s5_bpad_q;
  logic [PW-1:0]  s5_p_q;

  always_comb begin
    p5 = '0;
    for (int c = 0; c < NCH; c++) begin
      if (s4_nz_q[c]) begin
        p5 = PW'(c * 8) + PW'(s4_lidx_q[c]);
      end
    end
  end

  // stage 6: normalise to a Q31 mantissa
  logic [BPW-1:0] nb6;
  front_t         side6;
  front_t         s6_side_q;
  logic [31:0]    s6_m_q;

  always_comb begin
    nb6       = s5_bpad_q << (PW'(BPW - 1) - s5_p_q);
    side6     = s5_side_q;
    side6.l2e = 8'(s5_p_q) - 8'(FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_side_q  <= '0;
      s5_side_q  <= '0;
      s6_side_q  <= '0;
    end else begin
      s1_valid_q <= start && !busy;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_side_q  <= side4;
      s5_side_q  <= s4_side_q;
      s6_side_q  <= side6;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dneg_q <= diff_d[32];
    s1_dmag_q <= dmag_d;
    s2_dneg_q <= s1_dneg_q;
    s2_tmag_q <= prod2[64:FRAC_BITS];
    s3_tail_q <= tail3;
    s3_zero_q <= zero3;
    s3_fmax_q <= fmax3;
    s3_u_q    <= sq3[SQW-1:FRAC_BITS+1];
    s3_bmag_q <= b3[TW:0];
    s4_bpad_q <= bpad4;
    s4_nz_q   <= nz4;
    s4_lidx_q <= lidx4;
    s5_bpad_q <= s4_bpad_q;
    s5_p_q    <= p5;
    s6_m_q    <= nb6[BPW-1 -: 32];
  end

  // log2 fraction chain
  front_t      sq_side [N_SQR+1];
  logic [31:0] sq_m    [N_SQR+1];
  logic [27:0] sq_frac [N_SQR+1];

  assign sq_side[0] = s6_side_q;
  assign sq_m[0]    = s6_m_q;
  assign sq_frac[0] = '0;

  for (genvar i = 0; i < N_SQR; i++) begin : g_sqr
    cbpe_sqr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .side_i (sq_side[i]),
      .m_i    (sq_m[i]),
      .frac_i (sq_frac[i]),
      .side_o (sq_side[i+1]),
      .m_o    (sq_m[i+1]),
      .frac_o (sq_frac[i+1])
    );
  end

  // exponent times log2 of the base
  logic signed [23:0] n_s;
  logic signed [35:0] l2_s;
  logic signed [59:0] y_d;
  front_t             sl_side_q;
  logic signed [59:0] sl_y_q;

  always_comb begin
    n_s  = $signed({1'b0, tail_exp_q});
    l2_s = $signed({sq_side[N_SQR].l2e, sq_frac[N_SQR]});
    y_d  = n_s * l2_s;
  end

  // split the power of two into integer and fraction
  logic [59:0]       ymag;
  logic [VW-1:0]     vt, vsel;
  logic [31:0]       fr, f_d;
  back_t             bside_d;
  back_t             sv_side_q;
  logic [31:0]       sv_f_q;

  always_comb begin
    ymag    = sl_y_q[59] ? 60'(-sl_y_q) : 60'(sl_y_q);
    vt      = ymag[59:FRAC_BITS-4];
    vsel    = sl_side_q.in_tail ? vt : VW'(sl_side_q.core_v);
    fr      = vsel[31:0];
    bside_d.valid      = sl_side_q.valid;
    bside_d.in_tail    = sl_side_q.in_tail;
    bside_d.force_max  = sl_side_q.force_max;
    bside_d.force_zero = sl_side_q.force_zero;
    bside_d.up         = sl_side_q.in_tail && sl_y_q[59];
    // scaling up: round the power to the next integer, exponentiate the gap
    if (bside_d.up) begin
      bside_d.ipart = IPART_W'(vsel[VW-1:32]) + IPART_W'(fr != '0);
      f_d           = -fr;
    end else begin
      bside_d.ipart = IPART_W'(vsel[VW-1:32]);
      f_d           = fr;
    end
  end

  // fraction times ln2
  logic [63:0] rprod;
  back_t       hr_side [N_HORNER+1];
  logic [31:0] hr_r    [N_HORNER+1];
  logic [32:0] hr_s    [N_HORNER+1];
  back_t       sr_side_q;
  logic [31:0] sr_r_q;

  assign rprod      = 64'(sv_f_q) * 64'(LN2_Q32);
  assign hr_side[0] = sr_side_q;
  assign hr_r[0]    = sr_r_q;
  assign hr_s[0]    = ONE_Q32;

  for (genvar i = 0; i < N_HORNER; i++) begin : g_horner
    cbpe_horner_cell #(
      .K (N_HORNER - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .side_i (hr_side[i]),
      .r_i    (hr_r[i]),
      .s_i    (hr_s[i]),
      .side_o (hr_side[i+1]),
      .r_o    (hr_r[i+1]),
      .s_o    (hr_s[i+1])
    );
  end

  // scale times 2^-fraction
  logic [31:0] scale;
  logic [64:0] p_d;
  back_t       sp_side_q;
  logic [64:0] sp_p_q;

  always_comb begin
    scale = hr_side[N_HORNER].in_tail ? tail_scale_q : gauss_scale_q;
    p_d   = 65'(scale) * 65'(hr_s[N_HORNER]);
  end

  // integer shift and saturation
  logic [IPART_W-1:0] kk, ee;
  logic [64:0]        shr;
  logic [31:0]        dens_d;
  logic               done_q, tail_q;
  logic [31:0]        dens_q;

  always_comb begin
    kk     = sp_side_q.ipart;
    ee     = kk - IPART_W'(32);
    shr    = '0;
    dens_d = '0;
    if (sp_side_q.force_max) begin
      dens_d = DENS_MAX;
    end else if (sp_side_q.force_zero) begin
      dens_d = '0;
    end else if (!sp_side_q.up) begin
      if (kk < IPART_W'(32)) begin
        shr    = sp_p_q >> (7'(kk[4:0]) + 7'd32);
        dens_d = shr[31:0];
      end
    end else if (sp_p_q != '0) begin
      if (kk <= IPART_W'(32)) begin
        shr    = sp_p_q >> (6'd32 - 6'(kk[5:0]));
        dens_d = (shr[64:32] != '0) ? DENS_MAX : shr[31:0];
      end else if (ee >= IPART_W'(32)) begin
        dens_d = DENS_MAX;
      end else begin
        shr    = sp_p_q >> (6'd32 - 6'(ee[4:0]));
        dens_d = (shr != '0) ? DENS_MAX : (sp_p_q[31:0] << ee[4:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_side_q <= '0;
      sv_side_q <= '0;
      sr_side_q <= '0;
      sp_side_q <= '0;
      done_q    <= 1'b0;
    end else begin
      sl_side_q <= sq_side[N_SQR];
      sv_side_q <= bside_d;
      sr_side_q <= sv_side_q;
      sp_side_q <= hr_side[N_HORNER];
      done_q    <= sp_side_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sl_y_q <= y_d;
    sv_f_q <= f_d;
    sr_r_q <= rprod[63:32];
    sp_p_q <= p_d;
    dens_q <= dens_d;
    tail_q <= sp_side_q.in_tail;
  end

  assign done_o    = done_q;
  assign density_o = dens_q;
  assign in_tail_o = tail_q;

endmodule

`default_nettype wire

### rtl/cbpe_checker.sv
// ----------------------------------------------------------------------------
// cbpe_checker
// Port-level timing checks of the density evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);
  import cbpe_pkg::*;

  // every transaction gives its strobe after the fixed latency
  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result strobe missing after a start transaction");

  // no strobe without a transaction behind it
  a_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a start transaction");

  // back-to-back transactions give back-to-back strobes
  a_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) ##1 (start && !busy) |-> ##(LATENCY - 1) (done_o ##1 done_o))
    else $error("back-to-back results lost");

endmodule

bind crystal_ball_pdf_eval_unit cbpe_checker u_cbpe_checker (.*);

`default_nettype wire

### dv/crystal_ball_pdf_eval_unit_test.sv
// ----------------------------------------------------------------------------
// crystal_ball_pdf_eval_unit_test
// Self-checking bench for the Crystal Ball density evaluator. Samples are sent
// in random bursts under a series of register settings, including the
// extremes. A bit-accurate fixed-point predictor computes each density and
// region flag, and a scoreboard compares them in order with the block's
// results.
// ----------------------------------------------------------------------------
`default_nettype none

module crystal_ball_pdf_eval_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbpe_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam longint unsigned ONE = 64'h1_0000_0000;

  typedef struct {
    logic [31:0] density;
    logic        in_tail;
  } density_t;

  class density_scoreboard;
    logic [31:0] mean, inv_sigma, alpha, gauss_scale, tail_scale, tail_offset;
    logic [22:0] tail_exponent;
    density_t    pending[$];
    int unsigned errors, results, tail_results;

    function new();
      mean          = RST_MEAN;
      inv_sigma     = RST_INV_SIGMA;
      alpha         = RST_ALPHA;
      tail_exponent = RST_TAIL_EXPONENT;
      gauss_scale   = RST_GAUSS_SCALE;
      tail_scale    = RST_TAIL_SCALE;
      tail_offset   = RST_TAIL_OFFSET;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_MEAN:          mean = val;
        CFG_INV_SIGMA:     inv_sigma = val;
        CFG_ALPHA:         alpha = val;
        CFG_TAIL_EXPONENT: tail_exponent = val[22:0];
        CFG_GAUSS_SCALE:   gauss_scale = val;
        CFG_TAIL_SCALE:    tail_scale = val;
        CFG_TAIL_OFFSET:   tail_offset = val;
        default: ;
      endcase
    endfunction

    // 2^-f for a Q32 fraction, via a Horner series of e^-r
    function longint unsigned pow2_neg_frac(longint unsigned f);
      longint unsigned r, s;
      r = ((f & M32) * 64'(LN2_Q32)) >> 32;
      s = ONE;
      for (int k = 12; k >= 1; k--) begin
        s = ONE - ((r * s) >> 32) / longint'(k);
      end
      return s;
    endfunction

    function longint unsigned shrink(longint unsigned scale, longint unsigned v);
      longint unsigned k;
      k = v >> 32;
      if (k >= 32) return 0;
      return (scale * pow2_neg_frac(v & M32)) >> (32 + k);
    endfunction

    function longint unsigned grow(longint unsigned scale, longint unsigned v);
      longint unsigned c, g, p, e, q;
      c = (v >> 32) + ((v & M32) != 0);
      g = ((c << 32) - v) & M32;
      p = scale * pow2_neg_frac(g);
      if (p == 0) return 0;
      if (c <= 32) begin
        q = p >> (32 - c);
        return (q > M32) ? M32 : q;
      end
      e = c - 32;
      if (e >= 32 || p > (M32 >> e)) return M32;
      return p << e;
    endfunction

    // log2 of a positive Q16.16 value, signed Q28
    function longint log2_q28(longint unsigned b);
      int p;
      longint unsigned m;
      longint frac;
      p = 63;
      frac = 0;
      while (p > 0 && b[p] == 1'b0) p--;
      m = (p >= 31) ? (b >> (p - 31)) : (b << (31 - p));
      for (int i = 0; i < 28; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= ONE) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      return (longint'(p) - 16) * (longint'(1) << 28) + frac;
    endfunction

    function density_t evaluate(logic signed [31:0] x);
      density_t res;
      logic signed [31:0] mean_s, off_s;
      longint d, t, b, y, x_l, mean_l;
      longint unsigned dmag, tmag, u, v;
      mean_s = mean;
      off_s  = tail_offset;
      x_l    = x;
      mean_l = mean_s;
      d = x_l - mean_l;
      dmag = (d < 0) ? longint'(-d) : d;
      tmag = (dmag * longint'({32'b0, inv_sigma})) >> 16;
      t = (d < 0) ? -longint'(tmag) : longint'(tmag);
      if (t > -longint'({32'b0, alpha})) begin
        res.in_tail = 1'b0;
        if (tmag >= (64'd12 << 16)) begin
          res.density = '0;
        end else begin
          u = (tmag * tmag) >> 17;
          v = (u * 64'(LOG2E_Q30)) >> 14;
          res.density = 32'(shrink({32'b0, gauss_scale}, v));
        end
      end else begin
        res.in_tail = 1'b1;
        b = longint'(off_s) - t;
        if (b <= 0) begin
          res.density = DENS_MAX;
        end else begin
          y = longint'({41'b0, tail_exponent}) * log2_q28(b);
          if (y >= 0) begin
            res.density = 32'(shrink({32'b0, tail_scale}, longint'(y) >> 12));
          end else begin
            res.density = 32'(grow({32'b0, tail_scale}, longint'(-y) >> 12));
          end
        end
      end
      return res;
    endfunction

    function void note_sample(logic signed [31:0] x);
      pending.push_back(evaluate(x));
    endfunction

    function void check_result(logic [31:0] density, logic in_tail);
      density_t want;
      results++;
      if (in_tail) tail_results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result density=%h in_tail=%b", $realtime, density, in_tail);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (density !== want.density) begin
        $display("%0t: density expected %h actual %h", $realtime, want.density, density);
        errors++;
      end
      if (in_tail !== want.in_tail) begin
        $display("%0t: in_tail expected %b actual %b", $realtime, want.in_tail, in_tail);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] sample_x_i = '0;
  logic done_o;
  logic [31:0] density_o;
  logic in_tail_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  density_scoreboard density_sb = new();
  int unsigned idle_cycles = 0;
  int unsigned samples_sent = 0;
  int unsigned settings_used = 0;
  int unsigned gap_percent = 0;

  always #1 clk_i = ~clk_i;

  crystal_ball_pdf_eval_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .sample_x_i  (sample_x_i),
    .done_o      (done_o),
    .density_o   (density_o),
    .in_tail_o   (in_tail_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) density_sb.check_result(density_o, in_tail_o);
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("crystal_ball_pdf_eval_unit verification failed");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    density_sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // hold start high across a burst; the caller lowers it for a gap
  task automatic send_sample(logic signed [31:0] x);
    start = 1'b1;
    sample_x_i = x;
    do @(posedge clk_i); while (busy);
    density_sb.note_sample(x);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (density_sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic apply_setting(logic [31:0] m, logic [31:0] is, logic [31:0] a,
                               logic [31:0] n, logic [31:0] gs, logic [31:0] ts,
                               logic [31:0] off);
    write_reg(CFG_MEAN, m);
    write_reg(CFG_INV_SIGMA, is);
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_TAIL_EXPONENT, n);
    write_reg(CFG_GAUSS_SCALE, gs);
    write_reg(CFG_TAIL_SCALE, ts);
    write_reg(CFG_TAIL_OFFSET, off);
    // an unused index must leave every register alone
    if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, $urandom);
    settings_used++;
  endtask

  function automatic logic [31:0] spread_value();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // mostly samples near the peak at random scales, the rest anywhere
  function automatic logic signed [31:0] pick_sample();
    logic signed [31:0] off;
    if ($urandom_range(0, 4) == 0) return $urandom;
    off = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) off = -off;
    return density_sb.mean + off;
  endfunction

  task automatic random_burst_run(int unsigned count);
    int unsigned left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_sample(pick_sample());
      left -= burst;
      if ($urandom_range(0, 99) < gap_percent) begin
        start = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    logic signed [31:0] m;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: extremes of x, the peak, edges of the core cut-off
    m = density_sb.mean;
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0);
    send_sample(m);
    send_sample(m + 1);
    send_sample(m - 1);
    send_sample(m + (32'sh1 <<< 16));
    send_sample(m - (32'sh1 <<< 16));
    send_sample(m - (32'sh1 <<< 16) + 1);
    send_sample(m + (32'sh12 <<< 16));
    send_sample(m + (32'sd12 <<< 16));
    send_sample(m + (32'sd12 <<< 16) - 1);
    send_sample(m - (32'sd40 <<< 16));
    drain();

    // negative tail offset and saturating scales
    apply_setting(32'd0, 32'd65536, 32'd131072, 32'd196608, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, -32'sd65536);
    send_sample(-32'sd131072);
    send_sample(-32'sd65536);
    send_sample(-32'sd196608);
    send_sample(32'sh8000_0000);
    gap_percent = 0;
    random_burst_run(120);
    drain();

    // largest registers but the most negative mean, zero scales
    apply_setting(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4194304,
                  32'd0, 32'd0, 32'h7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    gap_percent = 50;
    random_burst_run(120);
    drain();

    // smallest registers but the most positive mean
    apply_setting(32'h7FFF_FFFF, 32'd1, 32'd1, 32'd65537, 32'd1, 32'd1, 32'h8000_0000);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    random_burst_run(120);
    drain();

    // zero exponent gives a flat tail
    apply_setting(32'd0, 32'd65536, 32'd65536, 32'd0, 32'd40685, 32'd98711,
                  32'd1 << 20);
    random_burst_run(120);
    drain();

    repeat (8) begin
      logic [31:0] off;
      off = spread_value();
      if ($urandom_range(0, 1)) off = -off;
      apply_setting($urandom, spread_value() | 32'd1, spread_value() | 32'd1,
                    ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(65537, 4194304),
                    spread_value(), spread_value(), off);
      gap_percent = $urandom_range(0, 80);
      random_burst_run(120);
      drain();
    end

    $display("%0d samples over %0d register settings, %0d results (%0d in the tail)",
             samples_sent, settings_used, density_sb.results, density_sb.tail_results);
    if (density_sb.errors == 0) begin
      $display("crystal_ball_pdf_eval_unit verification clean");
    end else begin
      $display("%0d mismatches", density_sb.errors);
      $display("crystal_ball_pdf_eval_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### crystal_ball_pdf_eval_unit.f
rtl/cbpe_pkg.sv
rtl/cbpe_sqr_cell.sv
rtl/cbpe_horner_cell.sv
rtl/crystal_ball_pdf_eval_unit.sv
rtl/cbpe_checker.sv
dv/crystal_ball_pdf_eval_unit_test.sv
